FILE: src/dpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpq_pkg
// types, codes and key compare shared by the dedup queue modules
// ----------------------------------------------------------------------------
package dpq_pkg;

  localparam int Capacity = 8;
  localparam int PtrW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int CntW = $clog2(Capacity + 1);
  localparam int PendW = 4;

  localparam logic [2:0] FUNC_ENQ  = 3'd0;
  localparam logic [2:0] FUNC_RTRY = 3'd1;
  localparam logic [2:0] FUNC_ACK  = 3'd2;
  localparam logic [2:0] FUNC_TAKE = 3'd3;
  localparam logic [2:0] FUNC_WIPE = 3'd4;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [63:0] key_word2;
    logic [63:0] key_word3;
    logic [31:0] ticket;
    logic [63:0] body;
  } dpq_in_t;

  typedef struct packed {
    logic        accepted;
    logic        persist;
    logic [63:0] out_word0;
    logic [63:0] out_word1;
    logic [63:0] out_word2;
    logic [63:0] out_word3;
    logic [31:0] out_ticket;
    logic [63:0] out_body;
    logic [3:0]  pending_count;
  } dpq_out_t;

  typedef struct packed {
    logic [63:0] w0;
    logic [63:0] w1;
    logic [63:0] w2;
    logic [63:0] w3;
    logic [31:0] ticket;
    logic [63:0] body;
  } dpq_rec_t;

  // controller to datapath
  typedef struct packed {
    logic scan_start;   // fetch head slot, load scan pointer with the slot after head
    logic scan_step;    // compare fetched slot, advance scan pointer
    logic push;         // write the request at tail
    logic pop;          // move head into in-flight slot
    logic arm;
    logic disarm;       // resend taken from the in-flight slot
    logic ack;
    logic wipe;
  } dpq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic           flight_valid;
    logic           resend_armed;
    logic           flight_hit;   // key and ticket match in-flight
    logic           flight_dup;   // key match in-flight
    logic           slot_dup;     // registered: set if any compare of the scan matched
    logic [CntW-1:0] fill;
  } dpq_stat_t;

  // bytes agree up to and including the first zero byte
  function automatic logic keys_equal(input logic [255:0] a, input logic [255:0] b);
    logic stop;
    logic eq;
    stop = 1'b0;
    eq = 1'b1;
    for (int i = 0; i < 32; i++) begin
      if (!stop) begin
        if (a[8*i +: 8] != b[8*i +: 8]) begin
          eq = 1'b0;
          stop = 1'b1;
        end else if (a[8*i +: 8] == 8'd0) begin
          stop = 1'b1;
        end
      end
    end
    return eq;
  endfunction

endpackage

FILE: src/dpq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpq_datapath
// record ring, in-flight slot, scan pointer and key comparators
// ----------------------------------------------------------------------------
module dpq_datapath import dpq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  dpq_in_t   req,
  input  dpq_cmd_t  cmd,
  output dpq_stat_t stat,
  output dpq_rec_t  flight
);

  logic [255:0]    ring_key [Capacity];
  logic [31:0]     ring_ticket [Capacity];
  logic [63:0]     ring_body [Capacity];
  logic [255:0]    scan_key_r;
  logic [PtrW-1:0] head_r, tail_r, scan_r;
  logic [CntW-1:0] fill_r;
  logic            fv_r, armed_r, dup_r;
  dpq_rec_t        flight_r;
  logic [255:0]    req_key, fl_key;

  assign req_key = {req.key_word3, req.key_word2, req.key_word1, req.key_word0};
  assign fl_key  = {flight_r.w3, flight_r.w2, flight_r.w1, flight_r.w0};

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Capacity - 1)) ? '0 : p + 1'b1;
  endfunction

  // ring memory: one write port, registered scan read
  // scan start fetches the head slot so the first compare sees it
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      ring_key[tail_r]    <= req_key;
      ring_ticket[tail_r] <= req.ticket;
      ring_body[tail_r]   <= req.body;
    end
    scan_key_r <= ring_key[cmd.scan_start ? head_r : scan_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.wipe) begin
      head_r  <= '0;
      tail_r  <= '0;
      scan_r  <= '0;
      fill_r  <= '0;
      fv_r    <= 1'b0;
      armed_r <= 1'b0;
      dup_r   <= 1'b0;
      flight_r <= '0;
    end else begin
      if (cmd.scan_start) begin
        scan_r <= inc(head_r);
        dup_r  <= 1'b0;
      end else if (cmd.scan_step) begin
        scan_r <= inc(scan_r);
        if (keys_equal(scan_key_r, req_key)) dup_r <= 1'b1;
      end
      if (cmd.push) begin
        tail_r <= inc(tail_r);
        fill_r <= fill_r + 1'b1;
      end
      if (cmd.pop) begin
        flight_r <= '{w0: ring_key[head_r][63:0], w1: ring_key[head_r][127:64],
                      w2: ring_key[head_r][191:128], w3: ring_key[head_r][255:192],
                      ticket: ring_ticket[head_r], body: ring_body[head_r]};
        head_r <= inc(head_r);
        fill_r <= fill_r - 1'b1;
        fv_r   <= 1'b1;
      end
      if (cmd.arm) armed_r <= 1'b1;
      if (cmd.disarm) armed_r <= 1'b0;
      if (cmd.ack) begin
        flight_r <= '0;
        fv_r     <= 1'b0;
        armed_r  <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.flight_valid = fv_r;
    stat.resend_armed = armed_r;
    stat.flight_dup   = fv_r && keys_equal(fl_key, req_key);
    stat.flight_hit   = stat.flight_dup && (flight_r.ticket == req.ticket);
    stat.slot_dup     = dup_r;
    stat.fill         = fill_r;
  end

  assign flight = flight_r;

  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CntW'(Capacity))
    else $error("fill count beyond capacity");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r == CntW'(Capacity) || fill_r == CntW'(tail_r - head_r)
    || fill_r == CntW'(tail_r + Capacity - head_r))
    else $error("pointers disagree with fill count");
  a_arm_fv: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r || fv_r)
    else $error("resend armed with nothing in flight");

endmodule

FILE: src/dpq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpq_ctrl
// request sequencer: decode, duplicate scan, commit, result register
// ----------------------------------------------------------------------------
module dpq_ctrl import dpq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      in_valid,
  output logic      in_ready,
  input  dpq_in_t   in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output dpq_out_t  out_data,
  output dpq_in_t   req,
  output dpq_cmd_t  cmd,
  input  dpq_stat_t stat,
  input  dpq_rec_t  flight
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  dpq_in_t         req_r;
  logic            en_r;
  logic [CntW-1:0] left_r, left_nxt;
  logic            ov_r, ov_nxt;
  dpq_out_t        od_r, od_nxt;
  logic            res_acc, res_per, res_emit;
  logic [CntW-1:0] fill_after;
  logic            fv_after;
  // emitted record comes from the in-flight slot in the cycle after commit
  logic            fill_rec_r;

  assign req = req_r;
  assign in_ready = (state_r == ST_IDLE) && !ov_r && !fill_rec_r;
  assign out_valid = ov_r;
  assign out_data = od_r;

  always_comb begin
    state_nxt = state_r;
    left_nxt  = left_r;
    cmd       = '0;
    res_acc   = 1'b0;
    res_per   = 1'b0;
    res_emit  = 1'b0;
    fill_after = stat.fill;
    fv_after  = stat.flight_valid;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        // clears the duplicate flag for every request
        cmd.scan_start = 1'b1;
        // enabled enqueue with no in-flight duplicate walks a non-empty ring; everything else commits at once
        if (req_r.func == FUNC_ENQ && en_r && !stat.flight_dup && stat.fill != '0) begin
          left_nxt  = stat.fill;
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        left_nxt = left_r - 1'b1;
        if (left_r == CntW'(1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        res_emit = 1'b1;
        state_nxt = ST_IDLE;
        case (req_r.func)
          FUNC_ENQ: begin
            if (en_r && !stat.flight_dup && !stat.slot_dup
                && stat.fill < CntW'(Capacity)) begin
              cmd.push = 1'b1;
              res_acc = 1'b1;
              fill_after = stat.fill + 1'b1;
            end
          end
          FUNC_RTRY: begin
            if (en_r && stat.flight_hit) begin
              cmd.arm = 1'b1;
              res_acc = 1'b1;
            end
          end
          FUNC_ACK: begin
            if (stat.flight_hit) begin
              cmd.ack = 1'b1;
              res_acc = 1'b1;
              fv_after = 1'b0;
            end
          end
          FUNC_TAKE: begin
            if (en_r && !stat.flight_valid && stat.fill != '0) begin
              cmd.pop = 1'b1;
              res_per = 1'b1;
              fill_after = stat.fill - 1'b1;
              fv_after = 1'b1;
            end else if (en_r && stat.flight_valid && stat.resend_armed) begin
              cmd.disarm = 1'b1;
              res_per = 1'b1;
            end
          end
          FUNC_WIPE: begin
            cmd.wipe = 1'b1;
            fill_after = '0;
            fv_after = 1'b0;
          end
          default: ;
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_we && !cfg_wdata) cmd.wipe = 1'b1;
  end

  always_comb begin
    ov_nxt = ov_r;
    od_nxt = od_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    if (res_emit) begin
      // a take result that emits a record waits for the in-flight record
      ov_nxt = !res_per;
      od_nxt = '0;
      od_nxt.accepted = res_acc;
      od_nxt.persist  = res_per;
      od_nxt.pending_count = PendW'(fill_after + CntW'(fv_after));
    end
    if (fill_rec_r) begin
      ov_nxt = 1'b1;
      od_nxt.out_word0  = flight.w0;
      od_nxt.out_word1  = flight.w1;
      od_nxt.out_word2  = flight.w2;
      od_nxt.out_word3  = flight.w3;
      od_nxt.out_ticket = flight.ticket;
      od_nxt.out_body   = flight.body;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      en_r    <= 1'b0;
      left_r  <= '0;
      fill_rec_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      left_r  <= left_nxt;
      fill_rec_r <= res_emit && res_per;
      if (cfg_we) en_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) req_r <= in_data;
    od_r <= od_nxt;
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> state_r == ST_IDLE)
    else $error("accept outside idle");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_emit |-> !ov_r) else $error("result overwritten");
  a_disarm_armed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.disarm |-> (stat.flight_valid && stat.resend_armed))
    else $error("resend without armed flight");

endmodule

FILE: src/dedup_persist_queue_with_retry_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dedup_persist_queue_with_retry_core
// deduplicating record queue with one in-flight slot and resend on retry
// ----------------------------------------------------------------------------
// One request at a time, passing through the load and done states from accept
// to result word. An enabled enqueue whose key is not in flight scans each
// queued record for duplicates in between, one ring slot a cycle through a
// registered memory port. A take that emits a record fills it in from the
// in-flight slot after commit. The input is not ready again until the result
// word is taken. Writing 0 to enable wipes the store in the same cycle.
module dedup_persist_queue_with_retry_core import dpq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  input  logic     in_valid,
  output logic     in_ready,
  input  dpq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output dpq_out_t out_data
);

  dpq_in_t   req;
  dpq_cmd_t  cmd;
  dpq_stat_t stat;
  dpq_rec_t  flight;

  dpq_ctrl u_ctrl (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .req, .cmd, .stat, .flight
  );

  dpq_datapath u_dp (
    .clk, .rst_n, .req, .cmd, .stat, .flight
  );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and checking for the deduplicating record queue with retry
// ----------------------------------------------------------------------------
// A model of the queue runs in the testbench and predicts the result word for
// every request word that the block accepts. Directed requests come first:
// duplicates, capacity, retry and acknowledge, unpadded keys, unknown codes
// and the disabled queue. Random requests follow, drawn mostly from a small
// pool of keys so that duplicates and matching tickets turn up often. The
// enable register is toggled between phases, and idling on both sides
// changes from phase to phase.
module testbench;
  import dpq_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     cfg_we;
  logic     cfg_wdata;
  logic     in_valid;
  logic     in_ready;
  dpq_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  dpq_out_t out_data;

  dedup_persist_queue_with_retry_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // state of the queue as the testbench sees it
  dpq_rec_t   ring_q [Capacity];
  int         head_q;
  int         tail_q;
  int         fill_q;
  dpq_rec_t   flight_q;
  logic       flight_on;
  logic       resend_on;
  logic       enable_q;

  dpq_in_t    pending_words [$];
  dpq_out_t   expected_words [$];
  logic [255:0] key_pool [16];
  logic [31:0]  ticket_pool [16];

  int send_idle_pct;
  int recv_idle_pct;
  int n_errors;
  int n_results;
  int n_persist;
  int n_accepts;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic logic keys_match(input logic [255:0] a, input logic [255:0] b);
    for (int i = 0; i < 32; i++) begin
      if (a[8*i +: 8] != b[8*i +: 8]) return 1'b0;
      if (a[8*i +: 8] == 8'd0) return 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic logic [255:0] rec_key(input dpq_rec_t r);
    return {r.w3, r.w2, r.w1, r.w0};
  endfunction

  function automatic logic [255:0] word_key(input dpq_in_t w);
    return {w.key_word3, w.key_word2, w.key_word1, w.key_word0};
  endfunction

  task automatic clear_queue_state();
    for (int i = 0; i < Capacity; i++) ring_q[i] = '0;
    head_q = 0;
    tail_q = 0;
    fill_q = 0;
    flight_q = '0;
    flight_on = 1'b0;
    resend_on = 1'b0;
  endtask

  function automatic logic flight_match(input dpq_in_t w);
    return flight_on && keys_match(rec_key(flight_q), word_key(w)) &&
           flight_q.ticket == w.ticket;
  endfunction

  // works out the result word for one request and updates the queue state
  task automatic predict_result(input dpq_in_t w);
    dpq_out_t r;
    logic     dup;
    int       p;
    r = '0;
    case (w.func)
      FUNC_ENQ: begin
        if (enable_q) begin
          dup = flight_on && keys_match(rec_key(flight_q), word_key(w));
          p = head_q;
          for (int i = 0; i < fill_q; i++) begin
            if (keys_match(rec_key(ring_q[p]), word_key(w))) dup = 1'b1;
            p = (p + 1) % Capacity;
          end
          if (!dup && fill_q < Capacity) begin
            ring_q[tail_q] = {w.key_word0, w.key_word1, w.key_word2, w.key_word3,
                              w.ticket, w.body};
            tail_q = (tail_q + 1) % Capacity;
            fill_q++;
            r.accepted = 1'b1;
          end
        end
      end
      FUNC_RTRY: begin
        if (enable_q && flight_match(w)) begin
          resend_on = 1'b1;
          r.accepted = 1'b1;
        end
      end
      FUNC_ACK: begin
        if (flight_match(w)) begin
          flight_q = '0;
          flight_on = 1'b0;
          resend_on = 1'b0;
          r.accepted = 1'b1;
        end
      end
      FUNC_TAKE: begin
        if (enable_q) begin
          if (flight_on) begin
            if (resend_on) begin
              resend_on = 1'b0;
              r.persist = 1'b1;
            end
          end else if (fill_q > 0) begin
            flight_q = ring_q[head_q];
            ring_q[head_q] = '0;
            head_q = (head_q + 1) % Capacity;
            fill_q--;
            flight_on = 1'b1;
            r.persist = 1'b1;
          end
          if (r.persist) begin
            r.out_word0 = flight_q.w0;
            r.out_word1 = flight_q.w1;
            r.out_word2 = flight_q.w2;
            r.out_word3 = flight_q.w3;
            r.out_ticket = flight_q.ticket;
            r.out_body = flight_q.body;
          end
        end
      end
      FUNC_WIPE: clear_queue_state();
      default: ;
    endcase
    r.pending_count = 4'(fill_q + (flight_on ? 1 : 0));
    expected_words.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    n_errors++;
    $display("mismatch on %s: got %h, expected %h", what, got, want);
  endtask

  // driver: one request word at a time from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_result(in_data);
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares result words and sets receiver idling
  always @(posedge clk) begin
    dpq_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected result word", 64'(out_data.pending_count), '0);
        end else begin
          want = expected_words.pop_front();
          n_results++;
          if (out_data.persist) n_persist++;
          if (out_data.accepted) n_accepts++;
          if (out_data.accepted !== want.accepted)
            report_mismatch("accepted", 64'(out_data.accepted), 64'(want.accepted));
          if (out_data.persist !== want.persist)
            report_mismatch("persist", 64'(out_data.persist), 64'(want.persist));
          if (out_data.out_word0 !== want.out_word0)
            report_mismatch("out_word0", out_data.out_word0, want.out_word0);
          if (out_data.out_word1 !== want.out_word1)
            report_mismatch("out_word1", out_data.out_word1, want.out_word1);
          if (out_data.out_word2 !== want.out_word2)
            report_mismatch("out_word2", out_data.out_word2, want.out_word2);
          if (out_data.out_word3 !== want.out_word3)
            report_mismatch("out_word3", out_data.out_word3, want.out_word3);
          if (out_data.out_ticket !== want.out_ticket)
            report_mismatch("out_ticket", 64'(out_data.out_ticket), 64'(want.out_ticket));
          if (out_data.out_body !== want.out_body)
            report_mismatch("out_body", out_data.out_body, want.out_body);
          if (out_data.pending_count !== want.pending_count)
            report_mismatch("pending_count", 64'(out_data.pending_count),
                            64'(want.pending_count));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic dpq_in_t make_word(input logic [2:0] f, input logic [255:0] k,
                                        input logic [31:0] t, input logic [63:0] b);
    dpq_in_t w;
    w.func = f;
    {w.key_word3, w.key_word2, w.key_word1, w.key_word0} = k;
    w.ticket = t;
    w.body = b;
    return w;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // key from the pool, sometimes with junk after the terminator
  function automatic logic [255:0] pool_key(input int i);
    logic [255:0] k;
    int           len;
    k = key_pool[i];
    len = 0;
    while (len < 32 && k[8*len +: 8] != 8'd0) len++;
    if (len < 31 && $urandom_range(3) == 0) begin
      for (int j = len + 1; j < 32; j++) k[8*j +: 8] = 8'($urandom());
    end
    return k;
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (15) @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (!v) clear_queue_state();
    enable_q = v;
  endtask

  task automatic add_random_words(input int count);
    dpq_in_t w;
    int      i;
    int      sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      i = $urandom_range(15);
      if (sel < 35) begin
        w = make_word(FUNC_ENQ, pool_key(i), ticket_pool[i], rand64());
      end else if (sel < 55) begin
        w = make_word(FUNC_TAKE, rand64(), $urandom(), rand64());
      end else if (sel < 72) begin
        // ack or retry of a pool key with its ticket, sometimes off by ticket
        w = make_word($urandom_range(1) ? FUNC_ACK : FUNC_RTRY, rec_key(flight_q),
                      flight_q.ticket, rand64());
        w = make_word(w.func, pool_key(i), ticket_pool[i], rand64());
        if ($urandom_range(4) == 0) w.ticket = $urandom();
      end else if (sel < 76) begin
        w = make_word(FUNC_WIPE, rand64(), $urandom(), rand64());
      end else if (sel < 79) begin
        w = make_word(3'($urandom_range(7, 5)), rand64(), $urandom(), rand64());
      end else begin
        w = make_word(3'($urandom_range(2)), {rand64(), rand64(), rand64(), rand64()},
                      $urandom(), rand64());
      end
      pending_words.push_back(w);
    end
  endtask

  initial begin
    logic [255:0] k;
    int           len;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    send_idle_pct = 13;
    recv_idle_pct = 72;
    n_errors = 0;
    n_results = 0;
    n_persist = 0;
    n_accepts = 0;
    enable_q = 1'b0;
    clear_queue_state();
    for (int i = 0; i < 16; i++) begin
      k = '0;
      len = (i == 0) ? 32 : (i == 1) ? 0 : $urandom_range(31, 1);
      for (int j = 0; j < len; j++) k[8*j +: 8] = 8'($urandom_range(255, 1));
      key_pool[i] = k;
      ticket_pool[i] = (i == 2) ? 32'hffff_ffff : $urandom();
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // disabled queue: everything answers nothing
    pending_words.push_back(make_word(FUNC_ENQ, key_pool[3], ticket_pool[3], '1));
    pending_words.push_back(make_word(FUNC_TAKE, '0, '0, '0));
    pending_words.push_back(make_word(FUNC_RTRY, key_pool[3], ticket_pool[3], '0));
    pending_words.push_back(make_word(FUNC_ACK, key_pool[3], ticket_pool[3], '0));
    pending_words.push_back(make_word(FUNC_WIPE, '0, '0, '0));
    wait_drained();
    write_enable(1'b1);

    // fill past capacity with a duplicate, an unpadded twin and extreme fields
    pending_words.push_back(make_word(FUNC_ENQ, key_pool[0], '1, '1));
    pending_words.push_back(make_word(FUNC_ENQ, key_pool[1], '0, '0));
    pending_words.push_back(make_word(FUNC_ENQ, key_pool[0], 32'd5, '0));
    k = key_pool[4];
    // junk only past the terminator, which stays in place
    for (int j = 31; j > 0; j--)
      if (k[8*j +: 8] == 8'd0 && k[8*(j-1) +: 8] == 8'd0) k[8*j +: 8] = 8'h5a;
    if (k != key_pool[4]) pending_words.push_back(make_word(FUNC_ENQ, k, 32'd9, '1));
    for (int i = 2; i < 10; i++)
      pending_words.push_back(make_word(FUNC_ENQ, key_pool[i], ticket_pool[i], rand64()));
    pending_words.push_back(make_word(FUNC_TAKE, '0, '0, '0));
    pending_words.push_back(make_word(FUNC_TAKE, '0, '0, '0));
    pending_words.push_back(make_word(FUNC_ENQ, key_pool[0], '1, '1));
    pending_words.push_back(make_word(FUNC_RTRY, key_pool[0], 32'h0, '0));
    pending_words.push_back(make_word(FUNC_RTRY, key_pool[0], '1, '0));
    pending_words.push_back(make_word(FUNC_RTRY, key_pool[0], '1, '0));
    pending_words.push_back(make_word(FUNC_TAKE, '0, '0, '0));
    pending_words.push_back(make_word(FUNC_TAKE, '0, '0, '0));
    pending_words.push_back(make_word(FUNC_ACK, key_pool[0], '1, '0));
    pending_words.push_back(make_word(3'd7, '1, '1, '1));
    pending_words.push_back(make_word(FUNC_TAKE, '0, '0, '0));
    pending_words.push_back(make_word(FUNC_WIPE, '1, '1, '1));
    wait_drained();
    write_enable(1'b1);
    write_enable(1'b0);
    write_enable(1'b1);

    add_random_words(550);
    wait_drained();
    send_idle_pct = 72;
    recv_idle_pct = 13;
    write_enable(1'b0);
    add_random_words(40);
    wait_drained();
    write_enable(1'b1);
    add_random_words(500);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_words(520);
    wait_drained();

    $display("checked %0d result words, %0d records emitted, %0d requests accepted",
             n_results, n_persist, n_accepts);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule
